### rtl/mbdl_pkg.sv
// Package for the multi-limb binary-to-decimal leaf converter.
// Holds sizes, constants, payload and state types; used by every rtl module but mbdl_ram.
`default_nettype none
package mbdl_pkg;
   localparam int MAX_LIMBS  = 256;
   localparam int MAX_BLOCKS = 256;
   localparam int LIMB_W     = 64;
   localparam int REM_W      = 60;
   localparam int NUM_W      = REM_W + LIMB_W;
   localparam int LIMB_IDX_W = $clog2(MAX_LIMBS);
   localparam int BLOCK_W    = $clog2(MAX_BLOCKS);
   localparam int DIGITS     = 18;
   localparam int BCD_W      = 4 * DIGITS;
   localparam int POS_W      = 13;
   localparam logic [LIMB_W-1:0] TEN18      = 64'd1000000000000000000;
   // floor(2^123 / 10^18)
   localparam logic [LIMB_W-1:0] BARRETT_MU = 64'd10633823966279326983;
   localparam logic [5:0] CHAR_ZERO = 6'd48;

   localparam logic [1:0] CSR_LIMB_COUNT  = 2'd0;
   localparam logic [1:0] CSR_BLOCK_COUNT = 2'd1;
   localparam logic [1:0] CSR_LEAD_DIGITS = 2'd2;

   localparam logic ACT_LOAD    = 1'b0;
   localparam logic ACT_CONVERT = 1'b1;

   typedef struct packed {
      logic              action;
      logic [LIMB_W-1:0] limb_value;
   } mbdl_req_type;

   typedef struct packed {
      logic [5:0]       digit_char;
      logic [POS_W-1:0] digit_position;
      logic             last_of_block;
      logic             piece_done;
   } mbdl_rsp_type;

   typedef struct packed {
      logic              done;
      logic [LIMB_W-1:0] quo;
      logic [REM_W-1:0]  rem;
   } mbdl_div_res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_BCD,
      ST_EMIT
   } mbdl_state_type;

   typedef enum logic [1:0] {
      DS_IDLE,
      DS_MUL,
      DS_BACK,
      DS_FIX
   } mbdl_div_state_type;
endpackage
`default_nettype wire

### rtl/mbdl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module mbdl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

### rtl/mbdl_div.sv
// Barrett divider: (hi:lo) / 10^18 with hi below 10^18.
// One 32x32 multiply per cycle, then conditional subtracts; uses mbdl_pkg.
`default_nettype none
module mbdl_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [mbdl_pkg::REM_W-1:0]    hi,
   input  wire logic [mbdl_pkg::LIMB_W-1:0]   lo,
   output mbdl_pkg::mbdl_div_res_type         res
);
   mbdl_pkg::mbdl_div_state_type state_ff, state_in;
   logic                        done_ff, done_in;
   logic [2:0]                  step_ff, step_in;
   logic [mbdl_pkg::NUM_W-1:0]  x_ff, x_in;
   logic [95:0]                 acc_ff, acc_in;
   logic [31:0]                 w3_ff, w3_in;
   logic [mbdl_pkg::LIMB_W-1:0] quo_ff, quo_in;
   logic [mbdl_pkg::LIMB_W-1:0] rem_ff, rem_in;
   logic [31:0]                 mul_a, mul_b;
   logic [63:0]                 prod;
   logic [95:0]                 sum;
   logic                        col_end;

   // operand select for the single multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         mbdl_pkg::DS_MUL: begin
            // product scanning of x * mu, column by column
            case (step_ff)
               3'd0: begin
                  mul_a = x_ff[31:0];
                  mul_b = mbdl_pkg::BARRETT_MU[31:0];
               end
               3'd1: begin
                  mul_a = x_ff[63:32];
                  mul_b = mbdl_pkg::BARRETT_MU[31:0];
               end
               3'd2: begin
                  mul_a = x_ff[31:0];
                  mul_b = mbdl_pkg::BARRETT_MU[63:32];
               end
               3'd3: begin
                  mul_a = x_ff[95:64];
                  mul_b = mbdl_pkg::BARRETT_MU[31:0];
               end
               3'd4: begin
                  mul_a = x_ff[63:32];
                  mul_b = mbdl_pkg::BARRETT_MU[63:32];
               end
               3'd5: begin
                  mul_a = {4'd0, x_ff[123:96]};
                  mul_b = mbdl_pkg::BARRETT_MU[31:0];
               end
               3'd6: begin
                  mul_a = x_ff[95:64];
                  mul_b = mbdl_pkg::BARRETT_MU[63:32];
               end
               default: begin
                  mul_a = {4'd0, x_ff[123:96]};
                  mul_b = mbdl_pkg::BARRETT_MU[63:32];
               end
            endcase
         end
         mbdl_pkg::DS_BACK: begin
            // low 64 bits of quotient estimate * 10^18
            case (step_ff)
               3'd0: begin
                  mul_a = quo_ff[31:0];
                  mul_b = mbdl_pkg::TEN18[31:0];
               end
               3'd1: begin
                  mul_a = quo_ff[63:32];
                  mul_b = mbdl_pkg::TEN18[31:0];
               end
               default: begin
                  mul_a = quo_ff[31:0];
                  mul_b = mbdl_pkg::TEN18[63:32];
               end
            endcase
         end
         default: ;
      endcase
      prod = {32'd0, mul_a} * {32'd0, mul_b};
   end

   always_comb begin
      sum      = acc_ff + {32'd0, prod};
      col_end  = !step_ff[0] || (step_ff == 3'd7);
      state_in = state_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      x_in     = x_ff;
      acc_in   = acc_ff;
      w3_in    = w3_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      case (state_ff)
         mbdl_pkg::DS_IDLE: begin
            if (start) begin
               x_in     = {hi, lo};
               acc_in   = '0;
               step_in  = 3'd0;
               state_in = mbdl_pkg::DS_MUL;
            end
         end
         mbdl_pkg::DS_MUL: begin
            acc_in = col_end ? {32'd0, sum[95:32]} : sum;
            if (step_ff == 3'd6) begin
               w3_in = sum[31:0];
            end
            if (step_ff == 3'd7) begin
               // estimate = bits 186..123 of x * mu
               quo_in   = {sum[58:0], w3_ff[31:27]};
               step_in  = 3'd0;
               state_in = mbdl_pkg::DS_BACK;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         mbdl_pkg::DS_BACK: begin
            // the remainder is below 3 * 10^18, so 64-bit wrapping math is exact
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd0) begin
               rem_in = x_ff[63:0] - prod;
            end else begin
               rem_in = rem_ff - {prod[31:0], 32'd0};
            end
            if (step_ff == 3'd2) begin
               state_in = mbdl_pkg::DS_FIX;
            end
         end
         mbdl_pkg::DS_FIX: begin
            if (rem_ff >= mbdl_pkg::TEN18) begin
               rem_in = rem_ff - mbdl_pkg::TEN18;
               quo_in = quo_ff + 64'd1;
            end else begin
               done_in  = 1'b1;
               state_in = mbdl_pkg::DS_IDLE;
            end
         end
         default: state_in = mbdl_pkg::DS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbdl_pkg::DS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      step_ff <= step_in;
      x_ff    <= x_in;
      acc_ff  <= acc_in;
      w3_ff   <= w3_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign res.done = done_ff;
   assign res.quo  = quo_ff;
   assign res.rem  = rem_ff[mbdl_pkg::REM_W-1:0];
endmodule
`default_nettype wire

### rtl/mbdl_bcd.sv
// Shift-and-add-3 converter from a 60-bit remainder to 18 BCD digits.
// One bit per cycle; uses mbdl_pkg.
`default_nettype none
module mbdl_bcd (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [mbdl_pkg::REM_W-1:0]   value,
   output logic                              done,
   output logic      [mbdl_pkg::BCD_W-1:0]   digits
);
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [5:0]                  cnt_ff, cnt_in;
   logic [mbdl_pkg::REM_W-1:0]  val_ff, val_in;
   logic [mbdl_pkg::BCD_W-1:0]  bcd_ff, bcd_in;
   logic [mbdl_pkg::BCD_W-1:0]  adj;

   always_comb begin
      for (int i = 0; i < mbdl_pkg::DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                     : bcd_ff[4*i +: 4];
      end
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      bcd_in  = bcd_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'(mbdl_pkg::REM_W - 1);
         val_in  = value;
         bcd_in  = '0;
      end else if (busy_ff) begin
         bcd_in = {adj[mbdl_pkg::BCD_W-2:0], val_ff[mbdl_pkg::REM_W-1]};
         val_in = {val_ff[mbdl_pkg::REM_W-2:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      val_ff <= val_in;
      bcd_ff <= bcd_in;
   end

   assign done   = done_ff;
   assign digits = bcd_ff;
endmodule
`default_nettype wire

### rtl/multilimb_binary_to_decimal_leaf_top.sv
// Multi-limb binary-to-decimal leaf converter, radix 10^18.
// Channels: req_ (valid/stall) carries one word {action, limb_value}; a load
// word stores the next 64-bit limb, lowest limb first.
// A convert word divides the stored number by 10^18 in place and sends up to
// 18 digit words on rsp_ (valid/stall), least significant digit first, each
// with its padded position; positions below lead_digits are dropped.
// csr_ (valid/ready, ready always high) writes limb_count, block_count and
// lead_digits; write only while the block is idle.
// A convert walks the live limbs from the top: per limb a RAM read, eight
// multiply steps for the Barrett estimate, three for the back multiply, one
// to three correction checks and a write back; then the BCD conversion of the
// final remainder, then one digit position after another (18 in all). One
// convert is handled at a time: req_ stalls until it is done.
// The digit output register parts the channels: a new word is taken while the
// last digit still waits. A stalled rsp_ holds its word and pauses emission.
// Reset (synchronous, active high) clears the counters and registers to
// limb_count 1, block_count 128, lead_digits 0. Limb RAM is not cleared;
// only loaded entries are ever read.
// Depends on mbdl_pkg, mbdl_ram, mbdl_div, mbdl_bcd.
`default_nettype none
module multilimb_binary_to_decimal_leaf_top (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire mbdl_pkg::mbdl_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output mbdl_pkg::mbdl_rsp_type      rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [1:0]             csr_index,
   input  wire logic [12:0]            csr_data
);
   localparam int IW = mbdl_pkg::LIMB_IDX_W;
   localparam int BW = mbdl_pkg::BLOCK_W;

   mbdl_pkg::mbdl_state_type state_ff, state_in;

   // configuration
   logic [7:0]  limb_count_ff, limb_count_in;
   logic [7:0]  block_count_ff, block_count_in;
   logic [12:0] lead_ff, lead_in;

   // piece state
   logic [IW-1:0] loaded_ff, loaded_in;   // limbs loaded in this piece
   logic [IW-1:0] live_ff, live_in;       // limbs up to the highest nonzero
   logic [BW-1:0] block_ff, block_in;     // block produced by next convert

   // convert walk
   logic [IW-1:0]              j_ff, j_in;
   logic [IW-1:0]              newlive_ff, newlive_in;
   logic [mbdl_pkg::REM_W-1:0] r_ff, r_in;
   logic [4:0]                 c_ff, c_in;

   // digit output register
   logic                   rsp_valid_ff, rsp_valid_in;
   mbdl_pkg::mbdl_rsp_type rsp_ff, rsp_in;

   // RAM, divider, BCD hookups
   logic                        wr_en, rd_en;
   logic [IW-1:0]               wr_addr, rd_addr;
   logic [mbdl_pkg::LIMB_W-1:0] wr_data, rd_data;
   logic                        div_start, bcd_start, bcd_done;
   mbdl_pkg::mbdl_div_res_type  div_res;
   logic [mbdl_pkg::BCD_W-1:0]  bcd_digits;

   logic           req_take, out_free;
   logic [12:0]    g;
   logic [3:0]     dig;
   logic [BW-1:0]  first_block;

   mbdl_ram #(.WIDTH(mbdl_pkg::LIMB_W), .DEPTH(mbdl_pkg::MAX_LIMBS)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   mbdl_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .hi   (r_ff),
      .lo   (rd_data),
      .res  (div_res)
   );

   // take the final remainder as it is written, so the pass starts right away
   mbdl_bcd u_bcd (
      .clock (clock),
      .reset (reset),
      .start (bcd_start),
      .value (r_in),
      .done  (bcd_done),
      .digits(bcd_digits)
   );

   assign req_stall = (state_ff != mbdl_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // position = block * 18 + digit index
   assign g   = {1'b0, block_ff, 4'd0} + {4'd0, block_ff, 1'b0} + {8'd0, c_ff};
   assign dig = bcd_digits[4*(5'd17 - c_ff) +: 4];

   always_comb begin
      first_block    = BW'(block_count_in - 8'd1);
      state_in       = state_ff;
      limb_count_in  = limb_count_ff;
      block_count_in = block_count_ff;
      lead_in        = lead_ff;
      loaded_in      = loaded_ff;
      live_in        = live_ff;
      block_in       = block_ff;
      j_in           = j_ff;
      newlive_in     = newlive_ff;
      r_in           = r_ff;
      c_in           = c_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      wr_en          = 1'b0;
      wr_addr        = loaded_ff;
      wr_data        = req_data.limb_value;
      rd_en          = 1'b0;
      rd_addr        = j_ff;
      div_start      = 1'b0;
      bcd_start      = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            mbdl_pkg::CSR_LIMB_COUNT:  limb_count_in = csr_data[7:0];
            mbdl_pkg::CSR_BLOCK_COUNT: begin
               block_count_in = csr_data[7:0];
               block_in       = first_block;
            end
            mbdl_pkg::CSR_LEAD_DIGITS: lead_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         mbdl_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_data.action == mbdl_pkg::ACT_LOAD) begin
                  // drop loads past limb_count
                  if ({1'b0, loaded_ff} < {1'b0, limb_count_ff}) begin
                     wr_en     = 1'b1;
                     loaded_in = loaded_ff + IW'(1);
                     if (req_data.limb_value != '0) begin
                        live_in = loaded_ff + IW'(1);
                     end
                  end
               end else begin
                  r_in       = '0;
                  newlive_in = '0;
                  if (live_ff == '0) begin
                     bcd_start = 1'b1;
                     state_in  = mbdl_pkg::ST_BCD;
                  end else begin
                     j_in     = live_ff - IW'(1);
                     rd_en    = 1'b1;
                     rd_addr  = live_ff - IW'(1);
                     state_in = mbdl_pkg::ST_LOAD;
                  end
               end
            end
         end
         mbdl_pkg::ST_LOAD: begin
            div_start = 1'b1;
            state_in  = mbdl_pkg::ST_DIV;
         end
         mbdl_pkg::ST_DIV: begin
            if (div_res.done) begin
               // write the quotient back in place, carry the remainder down
               wr_en   = 1'b1;
               wr_addr = j_ff;
               wr_data = div_res.quo;
               r_in    = div_res.rem;
               if (newlive_ff == '0 && div_res.quo != '0) begin
                  newlive_in = j_ff + IW'(1);
               end
               if (j_ff == '0) begin
                  live_in   = (newlive_ff == '0 && div_res.quo != '0) ? IW'(1)
                                                                       : newlive_ff;
                  bcd_start = 1'b1;
                  state_in  = mbdl_pkg::ST_BCD;
               end else begin
                  j_in     = j_ff - IW'(1);
                  rd_en    = 1'b1;
                  rd_addr  = j_ff - IW'(1);
                  state_in = mbdl_pkg::ST_LOAD;
               end
            end
         end
         mbdl_pkg::ST_BCD: begin
            if (bcd_done) begin
               c_in     = 5'd17;
               state_in = mbdl_pkg::ST_EMIT;
            end
         end
         mbdl_pkg::ST_EMIT: begin
            if (out_free) begin
               if (g >= lead_ff) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.digit_char     = mbdl_pkg::CHAR_ZERO + {2'b00, dig};
                  rsp_in.digit_position = g;
                  rsp_in.last_of_block  = (c_ff == 5'd0) || (g == lead_ff);
                  rsp_in.piece_done     = (block_ff == '0);
               end
               c_in = c_ff - 5'd1;
               if (c_ff == 5'd0) begin
                  state_in = mbdl_pkg::ST_IDLE;
                  if (block_ff == '0) begin
                     loaded_in = '0;
                     live_in   = '0;
                     block_in  = first_block;
                  end else begin
                     block_in = block_ff - BW'(1);
                  end
               end
            end
         end
         default: state_in = mbdl_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= mbdl_pkg::ST_IDLE;
         limb_count_ff  <= 8'd1;
         block_count_ff <= 8'd128;
         lead_ff        <= '0;
         loaded_ff      <= '0;
         live_ff        <= '0;
         block_ff       <= BW'(127);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         limb_count_ff  <= limb_count_in;
         block_count_ff <= block_count_in;
         lead_ff        <= lead_in;
         loaded_ff      <= loaded_in;
         live_ff        <= live_in;
         block_ff       <= block_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      j_ff       <= j_in;
      newlive_ff <= newlive_in;
      r_ff       <= r_in;
      c_ff       <= c_in;
      rsp_ff     <= rsp_in;
   end
endmodule
`default_nettype wire
